// File: rtl/pwfr_pkg.sv
// shared types and constants for the pulse-width frame receiver
`timescale 1ns / 1ps

package pwfr_pkg;

    localparam int TICK_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CMP_W     = (TICK_W > CFG_W) ? TICK_W : CFG_W;
    localparam int SHIFT_W   = 64;
    localparam int PAYLOAD_W = 60;
    localparam int COUNT_W   = 8;
    localparam int NIB_W     = 4;
    localparam int NIB_N     = SHIFT_W / NIB_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP = 2'd2;

    localparam logic [CFG_W-1:0] ZERO_MIN_RST  = 16'd600;
    localparam logic [CFG_W-1:0] ONE_MIN_RST   = 16'd1400;
    localparam logic [CFG_W-1:0] FRAME_GAP_RST = 16'd4000;

    localparam logic [TICK_W-1:0] ELAPSED_MAX = {TICK_W{1'b1}};

    typedef struct packed {
        logic [CFG_W-1:0] zero_min;
        logic [CFG_W-1:0] one_min;
        logic [CFG_W-1:0] frame_gap;
    } t_cfg;

    typedef struct packed {
        logic                 frame_ok;
        logic [PAYLOAD_W-1:0] payload;
        logic [COUNT_W-1:0]   bit_total;
    } t_result;

endpackage

// File: rtl/pwfr_cfg_regs.sv
// configuration registers for the tick thresholds
`timescale 1ns / 1ps

module pwfr_cfg_regs
    import pwfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ZERO_MIN:  n_cfg.zero_min  = i_cfg_data;
                CFG_ONE_MIN:   n_cfg.one_min   = i_cfg_data;
                CFG_FRAME_GAP: n_cfg.frame_gap = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_min  <= ZERO_MIN_RST;
            r_cfg.one_min   <= ONE_MIN_RST;
            r_cfg.frame_gap <= FRAME_GAP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/pwfr_decoder.sv
// frame state, pulse-width bit decode and frame check
`timescale 1ns / 1ps

module pwfr_decoder
    import pwfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  logic    i_line_level,
    input  t_cfg    i_cfg,
    output logic    o_emit,
    output t_result o_result
);

    logic               r_in_frame, n_in_frame;
    logic [TICK_W-1:0]  r_elapsed, n_elapsed;
    logic               r_bit_taken, n_bit_taken;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [TICK_W-1:0]  elapsed_inc;
    logic [CMP_W-1:0]   el_cmp;
    logic [CMP_W-1:0]   zero_cmp;
    logic [CMP_W-1:0]   one_cmp;
    logic [CMP_W-1:0]   gap_cmp;
    logic [NIB_W-1:0]   nib_xor;
    logic [NIB_W:0]     parity;
    logic               frame_ok;

    assign elapsed_inc = (r_elapsed < ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign el_cmp      = CMP_W'(elapsed_inc);
    assign zero_cmp    = CMP_W'(i_cfg.zero_min);
    assign one_cmp     = CMP_W'(i_cfg.one_min);
    assign gap_cmp     = CMP_W'(i_cfg.frame_gap);

    // xor of nibbles one to fifteen
    always_comb begin
        nib_xor = '0;
        for (int n = 1; n < NIB_N; n++) begin
            nib_xor = nib_xor ^ r_shift[n*NIB_W +: NIB_W];
        end
    end

    assign parity   = {1'b0, nib_xor} + 1'b1;
    assign frame_ok = (r_count != '0) && (r_count[1:0] == 2'b00)
                    && (parity == {1'b0, r_shift[NIB_W-1:0]});

    always_comb begin
        n_in_frame  = r_in_frame;
        n_elapsed   = r_elapsed;
        n_bit_taken = r_bit_taken;
        n_shift     = r_shift;
        n_count     = r_count;
        o_emit      = 1'b0;
        if (i_take) begin
            if (!r_in_frame) begin
                if (!i_line_level) begin
                    n_in_frame  = 1'b1;
                    n_elapsed   = '0;
                    n_bit_taken = 1'b0;
                    n_shift     = '0;
                    n_count     = '0;
                end
            end else if (el_cmp >= gap_cmp) begin
                o_emit      = 1'b1;
                n_in_frame  = 1'b0;
                n_elapsed   = '0;
                n_bit_taken = 1'b0;
            end else begin
                n_elapsed = elapsed_inc;
                if (i_line_level && !r_bit_taken) begin
                    if (el_cmp < one_cmp && el_cmp > zero_cmp) begin
                        n_shift     = {r_shift[SHIFT_W-2:0], 1'b0};
                        n_count     = r_count + 1'b1;
                        n_bit_taken = 1'b1;
                    end else if (el_cmp > one_cmp) begin
                        n_shift     = {r_shift[SHIFT_W-2:0], 1'b1};
                        n_count     = r_count + 1'b1;
                        n_bit_taken = 1'b1;
                    end
                end
                if (r_bit_taken && !i_line_level) begin
                    n_bit_taken = 1'b0;
                    n_elapsed   = '0;
                end
            end
        end
    end

    assign o_result.frame_ok  = frame_ok;
    assign o_result.payload   = frame_ok ? r_shift[SHIFT_W-1:NIB_W] : '0;
    assign o_result.bit_total = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_elapsed   <= '0;
            r_bit_taken <= 1'b0;
            r_shift     <= '0;
            r_count     <= '0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_elapsed   <= n_elapsed;
            r_bit_taken <= n_bit_taken;
            r_shift     <= n_shift;
            r_count     <= n_count;
        end
    end

endmodule

// File: rtl/pwfr_out_reg.sv
// result register holding one frame word until it is taken
`timescale 1ns / 1ps

module pwfr_out_reg
    import pwfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_ready,
    output logic    o_free,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/pulse_width_frame_receiver_core.sv
// top level of the pulse-width frame receiver
//
// channel  direction  handshake                  word
// in       input      i_in_valid / o_in_ready    i_line_level
// out      output     o_out_valid / i_out_ready  o_frame_ok, o_payload, o_bit_total
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one line sample is taken per cycle while o_in_ready is high; its decode finishes in that cycle
// a frame word appears in the cycle after the sample that closes the frame
// a new sample is taken while the result register is empty or being drained
// synchronous active-low reset clears frame state and loads default thresholds
// cfg is always ready; writes to an index past the frame gap are dropped
`timescale 1ns / 1ps

module pulse_width_frame_receiver_core
    import pwfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_line_level,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_frame_ok,
    output logic [PAYLOAD_W-1:0] o_payload,
    output logic [COUNT_W-1:0]   o_bit_total,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_result dec_result;
    t_result out_result;
    logic    take;
    logic    emit;
    logic    out_free;

    assign o_in_ready = out_free;
    assign take       = i_in_valid && out_free;

    pwfr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    pwfr_decoder u_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_line_level (i_line_level),
        .i_cfg        (cfg),
        .o_emit       (emit),
        .o_result     (dec_result)
    );

    pwfr_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit),
        .i_result    (dec_result),
        .i_out_ready (i_out_ready),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_frame_ok  = out_result.frame_ok;
    assign o_payload   = out_result.payload;
    assign o_bit_total = out_result.bit_total;

endmodule

// File: rtl/pwfr_checker.sv
// port-level checks for the pulse-width frame receiver
`timescale 1ns / 1ps

module pwfr_checker
    import pwfr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_frame_ok,
    input logic [PAYLOAD_W-1:0] o_payload,
    input logic [COUNT_W-1:0]   o_bit_total
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_payload)
            && $stable(o_frame_ok) && $stable(o_bit_total))
        else $error("result word changed while stalled");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_ok |-> o_payload == '0)
        else $error("rejected frame carries payload");

    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_ok |-> o_bit_total != '0 && o_bit_total[1:0] == 2'b00)
        else $error("accepted frame with bad bit count");

    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with result side free");

endmodule

bind pulse_width_frame_receiver_core pwfr_checker u_pwfr_checker (.*);
